>>> src/xbd_pkg.sv
// ----------------------------------------------------------------------------
// xbd_pkg
// Shared types, constants and helpers for the XTEA block decipher.
// ----------------------------------------------------------------------------
`default_nettype none

package xbd_pkg;

  // Data path widths
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 8;
  localparam int KEY_N   = 4;
  localparam int ADDR_W  = 5;
  localparam int IDX_W   = 3;

  // Register reset values
  localparam logic [WORD_W-1:0]  DELTA_RST  = 32'h9E37_79B9;
  localparam logic [COUNT_W-1:0] ROUNDS_RST = 8'd32;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [IDX_W-1:0] {
    REG_KEY0   = 3'd0,
    REG_KEY1   = 3'd1,
    REG_KEY2   = 3'd2,
    REG_KEY3   = 3'd3,
    REG_DELTA  = 3'd4,
    REG_ROUNDS = 3'd5
  } reg_idx_t;

  typedef logic [KEY_N-1:0][WORD_W-1:0] key_t;

  // Configuration as seen by the data path
  typedef struct packed {
    key_t                key;
    logic [WORD_W-1:0]   delta;
    logic [COUNT_W-1:0]  rounds;
  } cfg_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_INIT = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  // XTEA word mix: ((w << 4) ^ (w >> 5)) + w
  function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] w);
    return ((w << 4) ^ (w >> 5)) + w;
  endfunction

endpackage

`default_nettype wire

>>> src/xbd_in_if.sv
// ----------------------------------------------------------------------------
// xbd_in_if
// Ciphertext request channel: valid/ready with the two block halves.
// ----------------------------------------------------------------------------
`default_nettype none

interface xbd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] block_left;
  logic [31:0] block_right;

  modport source (output valid, output block_left, output block_right, input ready);
  modport sink   (input valid, input block_left, input block_right, output ready);
endinterface

`default_nettype wire

>>> src/xbd_out_if.sv
// ----------------------------------------------------------------------------
// xbd_out_if
// Plaintext result channel: valid/ready with the two deciphered halves.
// ----------------------------------------------------------------------------
`default_nettype none

interface xbd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] plain_left;
  logic [31:0] plain_right;

  modport source (output valid, output plain_left, output plain_right, input ready);
  modport sink   (input valid, input plain_left, input plain_right, output ready);
endinterface

`default_nettype wire

>>> src/xbd_cfg_regs.sv
// ----------------------------------------------------------------------------
// xbd_cfg_regs
// APB-style register file: key words, round constant and round count.
// ----------------------------------------------------------------------------
`default_nettype none

module xbd_cfg_regs
  import xbd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [WORD_W-1:0] cfg_pwdata,
  output logic      [WORD_W-1:0] cfg_prdata,
  output logic                   cfg_pready,
  output cfg_t                   cfg
);

  cfg_t           cfg_r;
  logic [IDX_W-1:0] idx;
  logic           wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[ADDR_W-1:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  // Write the addressed register; drop writes beyond the register list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key    <= '0;
      cfg_r.delta  <= DELTA_RST;
      cfg_r.rounds <= ROUNDS_RST;
    end else if (wr_en) begin
      case (idx)
        REG_KEY0:   cfg_r.key[0]  <= cfg_pwdata;
        REG_KEY1:   cfg_r.key[1]  <= cfg_pwdata;
        REG_KEY2:   cfg_r.key[2]  <= cfg_pwdata;
        REG_KEY3:   cfg_r.key[3]  <= cfg_pwdata;
        REG_DELTA:  cfg_r.delta   <= cfg_pwdata;
        REG_ROUNDS: cfg_r.rounds  <= cfg_pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (idx)
      REG_KEY0:   cfg_prdata = cfg_r.key[0];
      REG_KEY1:   cfg_prdata = cfg_r.key[1];
      REG_KEY2:   cfg_prdata = cfg_r.key[2];
      REG_KEY3:   cfg_prdata = cfg_r.key[3];
      REG_DELTA:  cfg_prdata = cfg_r.delta;
      REG_ROUNDS: cfg_prdata = {{(WORD_W-COUNT_W){1'b0}}, cfg_r.rounds};
      default:    cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> src/xbd_round_unit.sv
// ----------------------------------------------------------------------------
// xbd_round_unit
// Shared half-round unit: dst - (mix(src) ^ (sum + key[sel])).
// ----------------------------------------------------------------------------
`default_nettype none

module xbd_round_unit
  import xbd_pkg::*;
(
  input  wire logic [WORD_W-1:0] src_word,
  input  wire logic [WORD_W-1:0] dst_word,
  input  wire logic [WORD_W-1:0] sum,
  input  wire key_t              key,
  input  wire logic              low_sel,
  output logic      [WORD_W-1:0] dst_nxt
);

  logic [1:0]        key_idx;
  logic [WORD_W-1:0] key_sum;

  // Pick the key word: sum[12:11] for the right half, sum[1:0] for the left half
  assign key_idx = low_sel ? sum[1:0] : sum[12:11];
  assign key_sum = sum + key[key_idx];
  assign dst_nxt = dst_word - (mix_word(src_word) ^ key_sum);

endmodule

`default_nettype wire

>>> src/xtea_block_decipher.sv
// ----------------------------------------------------------------------------
// xtea_block_decipher
// XTEA decipher of one 64-bit block per request with a shared half-round unit.
// ----------------------------------------------------------------------------
// A block passes from acceptance through the INIT state, which forms the
// starting sum with a 32x8 multiply, and then the RUN state. Each round uses
// the single half-round unit twice, once for the right half and once for the
// left. Zero rounds go from INIT straight to DONE. The input is not ready from
// acceptance until the result has been taken, and it is ready again the cycle
// after that, so a stall on the result side holds off the next block. Key,
// round constant and round count are written through the APB-style port at
// byte addresses 0x00..0x14; the user must change them only while the block
// is idle, as the block itself does not enforce this.
`default_nettype none

module xtea_block_decipher
  import xbd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  xbd_in_if.sink                 in_chan,
  xbd_out_if.source              out_chan,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [WORD_W-1:0] cfg_pwdata,
  output logic      [WORD_W-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  cfg_t                  cfg;
  state_t                state_r, state_nxt;
  logic [WORD_W-1:0]     left_r, left_nxt;
  logic [WORD_W-1:0]     right_r, right_nxt;
  logic [WORD_W-1:0]     sum_r, sum_nxt;
  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;
  logic                  phase_r, phase_nxt;
  logic [WORD_W+COUNT_W-1:0] sum_prod;
  logic [WORD_W-1:0]     unit_src, unit_dst, unit_out;
  logic                  in_acc, out_acc;

  xbd_cfg_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Phase 0 updates the right half, phase 1 the left half
  assign unit_src = phase_r ? right_r : left_r;
  assign unit_dst = phase_r ? left_r  : right_r;

  xbd_round_unit u_round (
    .src_word (unit_src),
    .dst_word (unit_dst),
    .sum      (sum_r),
    .key      (cfg.key),
    .low_sel  (phase_r),
    .dst_nxt  (unit_out)
  );

  // Handshakes
  assign in_chan.ready        = (state_r == ST_IDLE);
  assign out_chan.valid       = (state_r == ST_DONE);
  assign out_chan.plain_left  = left_r;
  assign out_chan.plain_right = right_r;
  assign in_acc  = in_chan.valid & in_chan.ready;
  assign out_acc = out_chan.valid & out_chan.ready;

  // Starting sum = delta * rounds, modulo 2^32
  assign sum_prod = {{COUNT_W{1'b0}}, cfg.delta} * {{WORD_W{1'b0}}, cfg.rounds};

  // Sequencer and data path next state
  always_comb begin
    state_nxt = state_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          left_nxt  = in_chan.block_left;
          right_nxt = in_chan.block_right;
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        sum_nxt   = sum_prod[WORD_W-1:0];
        cnt_nxt   = cfg.rounds;
        phase_nxt = 1'b0;
        state_nxt = (cfg.rounds == '0) ? ST_DONE : ST_RUN;
      end
      ST_RUN: begin
        if (!phase_r) begin
          right_nxt = unit_out;
          sum_nxt   = sum_r - cfg.delta;
          phase_nxt = 1'b1;
        end else begin
          left_nxt  = unit_out;
          phase_nxt = 1'b0;
          cnt_nxt   = cnt_r - COUNT_W'(1);
          if (cnt_r == COUNT_W'(1)) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_acc) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    left_r  <= left_nxt;
    right_r <= right_nxt;
    sum_r   <= sum_nxt;
  end

  // Never offer a result while taking a new request
  a_busy_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> !in_chan.ready)
    else $error("result valid while input ready");

  // Accepted request moves to sum setup
  a_acc_init: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_INIT))
    else $error("accepted request did not enter setup");

  // Rounds remain while running
  a_run_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (cnt_r != '0))
    else $error("running with zero rounds left");

  // Zero rounds go straight to the result
  a_zero_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_INIT) && (cfg.rounds == '0)) |=> (state_r == ST_DONE))
    else $error("zero-round block did not pass through");

  // Last half-round finishes the block
  a_last_round: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RUN) && phase_r && (cnt_r == COUNT_W'(1))) |=> (state_r == ST_DONE))
    else $error("block did not finish after last round");

endmodule

`default_nettype wire
